[rtl/core/dense_row_mac_with_poly_gelu_core_macros.svh]
// Assertion macros shared by the dense row MAC core
`ifndef DENSE_ROW_MAC_WITH_POLY_GELU_CORE_MACROS_SVH
`define DENSE_ROW_MAC_WITH_POLY_GELU_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DRMG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DRMG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/drmg_pkg.sv]
// Types and constants of the dense row MAC core
package drmg_pkg;

    // Operand, accumulator and result widths
    localparam int OPD_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W = 48;
    localparam int OUT_W = 32;

    // Row-sum queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;
    localparam int Q_CW = 3;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Queue status seen by both sides
    typedef struct packed {
        logic            empty;
        logic [Q_CW-1:0] level;
    } t_q_stat;

endpackage

[rtl/core/drmg_queue.sv]
// Short queue of finished row sums between the MAC front and the polynomial back
`include "dense_row_mac_with_poly_gelu_core_macros.svh"

module drmg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  drmg_pkg::t_acc    i_push_data,
    input  logic              i_pop,
    output drmg_pkg::t_acc    o_head,
    output drmg_pkg::t_q_stat o_stat
);

    localparam logic [drmg_pkg::Q_CW-1:0] LVL_FULL = drmg_pkg::Q_CW'(drmg_pkg::Q_DEPTH);

    drmg_pkg::t_acc r_mem [drmg_pkg::Q_DEPTH];

    logic [drmg_pkg::Q_AW-1:0] r_wr_ptr;
    logic [drmg_pkg::Q_AW-1:0] r_rd_ptr;
    logic [drmg_pkg::Q_CW-1:0] r_level;
    logic [drmg_pkg::Q_CW-1:0] n_level;

    // Store pushed sums
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Track level across push and pop
    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + drmg_pkg::Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - drmg_pkg::Q_CW'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + drmg_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + drmg_pkg::Q_AW'(1);
            end
            r_level <= n_level;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_level == '0);
    assign o_stat.level = r_level;

    `DRMG_ASSERT_IMP(a_no_overflow, i_push && !i_pop, r_level != LVL_FULL, "queue push while full")
    `DRMG_ASSERT_IMP(a_no_underflow, i_pop, r_level != '0, "row queue pop while empty")

endmodule

[rtl/core/drmg_front.sv]
// MAC front: takes weight/activation beats and accumulates row sums
module drmg_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [drmg_pkg::OPD_W-1:0]   i_weight,
    input  logic signed [drmg_pkg::OPD_W-1:0]   i_activation,
    input  logic signed [drmg_pkg::OPD_W-1:0]   i_bias,
    input  logic                                i_first_term,
    input  logic                                i_last_term,
    input  drmg_pkg::t_q_stat                   i_q_stat,
    output logic                                o_push,
    output drmg_pkg::t_acc                      o_push_data
);

    localparam int EXT_W = drmg_pkg::ACC_W - drmg_pkg::OPD_W;
    localparam int PEXT_W = drmg_pkg::ACC_W + 1 - drmg_pkg::PROD_W;

    logic                                  r_s1_vld;
    logic signed [drmg_pkg::PROD_W-1:0]    r_s1_prod;
    logic signed [drmg_pkg::OPD_W-1:0]     r_s1_bias;
    logic                                  r_s1_first;
    logic                                  r_s1_last;
    drmg_pkg::t_acc                        r_acc;

    logic                                  accept;
    logic                                  s1_push;
    drmg_pkg::t_acc                        base;
    logic signed [drmg_pkg::ACC_W:0]       sum_wide;
    drmg_pkg::t_acc                        n_acc;

    // Hold input while the queue cannot take what is already in flight
    assign s1_push = r_s1_vld && r_s1_last;
    assign o_stall = ({1'b0, i_q_stat.level} + {{drmg_pkg::Q_CW{1'b0}}, s1_push})
                     >= (drmg_pkg::Q_CW + 1)'(drmg_pkg::Q_DEPTH);
    assign accept  = i_valid && !o_stall;

    // Stage 1: multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_prod  <= i_weight * i_activation;
            r_s1_bias  <= i_bias;
            r_s1_first <= i_first_term;
            r_s1_last  <= i_last_term;
        end
    end

    // Stage 2: load bias or add to running sum, saturate at 48 bits
    always_comb begin
        if (r_s1_first) begin
            base = {{EXT_W{r_s1_bias[drmg_pkg::OPD_W-1]}}, r_s1_bias} <<< FRAC_BITS;
        end else begin
            base = r_acc;
        end
        sum_wide = {base[drmg_pkg::ACC_W-1], base}
                 + {{PEXT_W{r_s1_prod[drmg_pkg::PROD_W-1]}}, r_s1_prod};
        if (sum_wide[drmg_pkg::ACC_W] != sum_wide[drmg_pkg::ACC_W-1]) begin
            n_acc = {sum_wide[drmg_pkg::ACC_W], {(drmg_pkg::ACC_W-1){~sum_wide[drmg_pkg::ACC_W]}}};
        end else begin
            n_acc = sum_wide[drmg_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_s1_vld) begin
            r_acc <= n_acc;
        end
    end

    // Push the finished row sum
    assign o_push      = s1_push;
    assign o_push_data = n_acc;

endmodule

[rtl/core/drmg_back.sv]
// Polynomial back: saturates row sums, evaluates GELU or passes the sum through, holds the result beat
`include "dense_row_mac_with_poly_gelu_core_macros.svh"

module drmg_back #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_apply,
    input  drmg_pkg::t_q_stat                   i_q_stat,
    input  drmg_pkg::t_acc                      i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [drmg_pkg::OUT_W-1:0]   o_pre_activation,
    output logic signed [drmg_pkg::OUT_W-1:0]   o_post_activation,
    output logic                                o_saturated
);

    localparam int E = 2 * FRAC_BITS;
    localparam int SHL = (E < 20) ? (20 - E) : 0;
    localparam int SHR = (E > 20) ? (E - 20) : 0;
    localparam int YSH = 40 - E;
    localparam int X20_W = 26;
    localparam int X2_W = 30;
    localparam int X4_W = 40;
    localparam int T2_W = 49;
    localparam int T4_W = 57;
    localparam int Y_W = 60;

    localparam logic [18:0] C2 = 19'd506016;
    localparam logic [16:0] C4 = 17'd69831;
    localparam logic signed [Y_W-1:0] C0_Y = Y_W'(70906) <<< 20;
    localparam logic signed [drmg_pkg::ACC_W-1:0] LIMIT = drmg_pkg::ACC_W'(1) <<< (E + 5);
    localparam logic signed [drmg_pkg::OUT_W-1:0] OUT_MIN = {1'b1, {(drmg_pkg::OUT_W-1){1'b0}}};

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ1  = 3'd1;
    localparam logic [2:0] ST_SQ2  = 3'd2;
    localparam logic [2:0] ST_MUL4 = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    typedef struct packed {
        logic signed [drmg_pkg::OUT_W-1:0] value;
        logic                              clip;
    } t_sat;

    // Clip a wide signed value to 32 bits
    function automatic t_sat sat32(input logic signed [Y_W-1:0] v);
        t_sat r;
        r.clip = 1'b0;
        r.value = v[drmg_pkg::OUT_W-1:0];
        if (v > Y_W'(32'sh7fffffff)) begin
            r.clip = 1'b1;
            r.value = ~OUT_MIN;
        end else if (v < $signed({{(Y_W-drmg_pkg::OUT_W){1'b1}}, OUT_MIN})) begin
            r.clip = 1'b1;
            r.value = OUT_MIN;
        end
        return r;
    endfunction

    logic [2:0]                          r_state;
    logic signed [X20_W-1:0]             r_x20;
    logic [X2_W-1:0]                     r_x2;
    logic [X4_W-1:0]                     r_x4;
    logic [T2_W-1:0]                     r_t2;
    logic [T4_W-1:0]                     r_t4;
    logic signed [drmg_pkg::OUT_W-1:0]   r_pre;
    logic signed [drmg_pkg::OUT_W-1:0]   r_post;
    logic                                r_clip;

    logic                                r_out_vld;
    logic signed [drmg_pkg::OUT_W-1:0]   r_out_pre;
    logic signed [drmg_pkg::OUT_W-1:0]   r_out_post;
    logic                                r_out_sat;

    logic                                out_free;
    logic                                big_sum;
    t_sat                                pre_sat;
    t_sat                                post_sat;
    drmg_pkg::t_acc                      x20_full;
    logic signed [2*X20_W-1:0]           sq1;
    logic [2*X2_W-1:0]                   sq2;
    logic signed [Y_W-1:0]               y;
    logic signed [Y_W-1:0]               y_shr;

    assign out_free = !r_out_vld || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_stat.empty;

    // Classify the popped sum
    always_comb begin
        pre_sat  = sat32({{(Y_W-drmg_pkg::ACC_W){i_head[drmg_pkg::ACC_W-1]}}, i_head});
        big_sum  = (i_head >= LIMIT) || (i_head <= -LIMIT);
        x20_full = (i_head <<< SHL) >>> SHR;
    end

    // Square chain and final sum
    always_comb begin
        sq1   = r_x20 * r_x20;
        sq2   = r_x2 * r_x2;
        y     = C0_Y
              + ({{(Y_W-X20_W){r_x20[X20_W-1]}}, r_x20} <<< 19)
              + $signed({{(Y_W-T2_W){1'b0}}, r_t2})
              - $signed({{(Y_W-T4_W){1'b0}}, r_t4});
        y_shr = y >>> YSH;
        post_sat = sat32(y_shr);
    end

    // Step the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= (!i_apply || big_sum) ? ST_DONE : ST_SQ1;
                    end
                end
                ST_SQ1:  r_state <= ST_SQ2;
                ST_SQ2:  r_state <= ST_MUL4;
                ST_MUL4: r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_pre <= pre_sat.value;
                    r_x20 <= x20_full[X20_W-1:0];
                    if (!i_apply) begin
                        r_post <= pre_sat.value;
                        r_clip <= pre_sat.clip;
                    end else if (big_sum) begin
                        r_post <= OUT_MIN;
                        r_clip <= 1'b1;
                    end else begin
                        r_clip <= pre_sat.clip;
                    end
                end
            end
            ST_SQ1: begin
                r_x2 <= sq1[X2_W+19:20];
            end
            ST_SQ2: begin
                r_x4 <= sq2[X4_W+19:20];
                r_t2 <= C2 * r_x2;
            end
            ST_MUL4: begin
                r_t4 <= C4 * r_x4;
            end
            ST_SUM: begin
                r_post <= post_sat.value;
                r_clip <= r_clip | post_sat.clip;
            end
            default: begin
            end
        endcase
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_pre  <= r_pre;
            r_out_post <= r_post;
            r_out_sat  <= r_clip;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_pre_activation  = r_out_pre;
    assign o_post_activation = r_out_post;
    assign o_saturated       = r_out_sat;

    `DRMG_ASSERT_IMP(a_pass_through, r_out_vld && !i_apply, r_out_post == r_out_pre, "bad pass-through")
    `DRMG_ASSERT_NXT(a_done_lands, (r_state == ST_DONE) && !r_out_vld, r_out_vld, "row not loaded")

endmodule

[rtl/core/dense_row_mac_with_poly_gelu_core.sv]
// Top level of the dense row MAC with polynomial GELU
//
//   channel   handshake              payload
//   input     i_valid / o_stall      i_weight, i_activation, i_bias, i_first_term, i_last_term
//   output    o_valid / i_stall      o_pre_activation, o_post_activation, o_saturated
//   config    i_cfg_wr_en            i_cfg_wr_data (apply_activation)
//
// The MAC front takes one beat per cycle while o_stall is low; a row sum is pushed into the
// queue in the cycle after its last beat is accepted.
// With the polynomial the back steps from IDLE through SQ1, SQ2, MUL4 and SUM to DONE;
// in pass-through or for sums of magnitude 32 or more it goes from IDLE straight to DONE.
// A 4-entry row queue parts the two; input stalls when it would fill, so rows shorter
// than the back's row time stall the input. Output stalls hold the result register.
// Reset is synchronous, active low, and clears the accumulator and sets apply_activation.
module dense_row_mac_with_poly_gelu_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [drmg_pkg::OPD_W-1:0]   i_weight,
    input  logic signed [drmg_pkg::OPD_W-1:0]   i_activation,
    input  logic signed [drmg_pkg::OPD_W-1:0]   i_bias,
    input  logic                                i_first_term,
    input  logic                                i_last_term,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [drmg_pkg::OUT_W-1:0]   o_pre_activation,
    output logic signed [drmg_pkg::OUT_W-1:0]   o_post_activation,
    output logic                                o_saturated
);

    logic              r_apply;
    logic              q_push;
    drmg_pkg::t_acc    q_push_data;
    logic              q_pop;
    drmg_pkg::t_acc    q_head;
    drmg_pkg::t_q_stat q_stat;

    // Activation enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_apply <= i_cfg_wr_data;
        end
    end

    drmg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_weight     (i_weight),
        .i_activation (i_activation),
        .i_bias       (i_bias),
        .i_first_term (i_first_term),
        .i_last_term  (i_last_term),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_push_data  (q_push_data)
    );

    drmg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    drmg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_apply           (r_apply),
        .i_q_stat          (q_stat),
        .i_head            (q_head),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pre_activation  (o_pre_activation),
        .o_post_activation (o_post_activation),
        .o_saturated       (o_saturated)
    );

endmodule
